>>> hdl/eaf_pkg.sv
// Shared types, widths and the log2 table of the elliptical alpha falloff block.
package eaf_pkg;

	// Field and register widths.
	localparam int COORD_BITS     = 12;
	localparam int DIST_FRAC_BITS = 10;
	localparam int SIZE_W         = 13;
	localparam int COEF_W         = 17;
	localparam int ALPHA_W        = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 17;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_COEF_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_COEF_Y = 2'd3;

	// Register reset values.
	localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 13'd256;
	localparam logic [COEF_W-1:0] RST_RECIP_COEF = 17'd512;

	// Datapath widths of the distance computation.
	localparam int MAG_W  = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
	localparam int PROD_W = MAG_W + COEF_W;
	localparam int SAT_W  = 32;
	localparam int P_W    = (PROD_W > SAT_W) ? SAT_W : PROD_W;
	localparam int SQ_W   = 2 * P_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int DIST_SHIFT = 34 - DIST_FRAC_BITS;
	localparam int DIST_W = DIST_FRAC_BITS + 1;
	localparam int DIST_ONE = 1 << DIST_FRAC_BITS;

	// Alpha search widths.
	localparam int LOG_W  = 35;
	localparam int RHS_W  = DIST_W + LOG_W;
	localparam int SRCH_STEPS = ALPHA_W;

	// Queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// Register file as seen by the datapath.
	typedef struct packed {
		logic [SIZE_W-1:0] image_width;
		logic [SIZE_W-1:0] image_height;
		logic [COEF_W-1:0] recip_coef_x;
		logic [COEF_W-1:0] recip_coef_y;
	} cfg_t;

	// Word passed from the front part to the back part.
	typedef struct packed {
		logic              in_ellipse;
		logic [DIST_W-1:0] distance;
	} mid_word_t;

	// Word holding one finished result.
	typedef struct packed {
		logic               in_ellipse;
		logic [ALPHA_W-1:0] alpha;
	} res_word_t;

	localparam int MID_W  = $bits(mid_word_t);
	localparam int RES_W  = $bits(res_word_t);
	localparam int WORD_W = (MID_W > RES_W) ? MID_W : RES_W;

	typedef logic [WORD_W-1:0] word_t;

	// log2 table indexed by alpha value, unsigned Q3.32.
	typedef logic [LOG_W-1:0] log2_tbl_t [256];

	// log2 of v by repeated squaring of a Q1.31 mantissa, each square truncated.
	function automatic logic [LOG_W-1:0] log2_q32(input int unsigned v);
		int unsigned n;
		logic [63:0] m;
		logic [63:0] r;
		n = 0;
		for (int i = 1; i < 8; i++) begin
			if ((v >> i) != 0)
				n = i;
		end
		m = 64'(v) << (31 - n);
		r = 64'(n) << 32;
		for (int i = 31; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				r = r | (64'd1 << i);
			end
		end
		if (v == 0)
			r = '0;
		return r[LOG_W-1:0];
	endfunction

	function automatic log2_tbl_t build_log2_tbl();
		log2_tbl_t t;
		for (int i = 0; i < 256; i++)
			t[i] = log2_q32(i);
		return t;
	endfunction

	localparam log2_tbl_t LOG2_TBL = build_log2_tbl();

endpackage

>>> hdl/eaf_fifo.sv
// Small synchronous queue of words with full and empty flags.
module eaf_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  eaf_pkg::word_t      wdata,
	output logic                full,
	input  logic                pop,
	output eaf_pkg::word_t      rdata,
	output logic                empty
);

	eaf_pkg::word_t                     mem_q [eaf_pkg::FIFO_DEPTH];
	logic [eaf_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [eaf_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [eaf_pkg::FIFO_CNT_W-1:0]     count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = (count_q == eaf_pkg::FIFO_CNT_W'(eaf_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

>>> hdl/eaf_front.sv
// Front part: scaled offsets, squared distance and the inside test for each pixel.
module eaf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  eaf_pkg::cfg_t                 cfg,
	input  logic                          push,
	input  logic [eaf_pkg::COORD_BITS-1:0] pixel_x,
	input  logic [eaf_pkg::COORD_BITS-1:0] pixel_y,
	output logic                          full,
	output logic                          out_push,
	output eaf_pkg::word_t                out_word,
	input  logic                          out_full
);

	logic                          adv;
	logic                          take;
	logic [eaf_pkg::MAG_W:0]       twice_x;
	logic [eaf_pkg::MAG_W:0]       twice_y;
	logic [eaf_pkg::MAG_W:0]       size_x;
	logic [eaf_pkg::MAG_W:0]       size_y;
	logic [eaf_pkg::MAG_W:0]       diff_x;
	logic [eaf_pkg::MAG_W:0]       diff_y;
	logic [eaf_pkg::PROD_W-1:0]    prod_x;
	logic [eaf_pkg::PROD_W-1:0]    prod_y;
	logic [eaf_pkg::P_W-1:0]       pt_x;
	logic [eaf_pkg::P_W-1:0]       pt_y;
	logic                          sat;
	logic [eaf_pkg::SUM_W-1:0]     sum;
	logic [eaf_pkg::SUM_W-1:0]     hi;
	logic                          in_ellipse;
	eaf_pkg::mid_word_t            mid;

	logic                          v_s1, v_s2, v_s3;
	logic [eaf_pkg::PROD_W-1:0]    p_x_s1, p_y_s1;
	logic [eaf_pkg::SQ_W-1:0]      sq_x_s2, sq_y_s2;
	logic                          sat_s2;
	eaf_pkg::mid_word_t            mid_s3;

	// The whole front advances unless its last word is blocked by the queue.
	assign adv      = !(v_s3 && out_full);
	assign full     = !adv;
	assign take     = push && adv;
	assign out_push = v_s3 && !out_full;
	assign out_word = eaf_pkg::WORD_W'(mid_s3);

	// Offsets from the center in half pixels, then scaled by the reciprocal radius.
	always_comb begin
		twice_x = (eaf_pkg::MAG_W + 1)'({pixel_x, 1'b0});
		twice_y = (eaf_pkg::MAG_W + 1)'({pixel_y, 1'b0});
		size_x  = (eaf_pkg::MAG_W + 1)'(cfg.image_width);
		size_y  = (eaf_pkg::MAG_W + 1)'(cfg.image_height);
		diff_x  = (twice_x >= size_x) ? twice_x - size_x : size_x - twice_x;
		diff_y  = (twice_y >= size_y) ? twice_y - size_y : size_y - twice_y;
		prod_x  = eaf_pkg::PROD_W'(diff_x[eaf_pkg::MAG_W-1:0]) *
			eaf_pkg::PROD_W'(cfg.recip_coef_x);
		prod_y  = eaf_pkg::PROD_W'(diff_y[eaf_pkg::MAG_W-1:0]) *
			eaf_pkg::PROD_W'(cfg.recip_coef_y);
	end

	// A product that reaches 2^P_W (at most 2^32) sets sat, which always marks the pixel outside.
	always_comb begin
		sat  = ((p_x_s1 >> eaf_pkg::P_W) != '0) || ((p_y_s1 >> eaf_pkg::P_W) != '0);
		pt_x = p_x_s1[eaf_pkg::P_W-1:0];
		pt_y = p_y_s1[eaf_pkg::P_W-1:0];
	end

	// Sum of squares truncated to the distance, and the inside test.
	always_comb begin
		sum        = eaf_pkg::SUM_W'(sq_x_s2) + eaf_pkg::SUM_W'(sq_y_s2);
		hi         = sum >> eaf_pkg::DIST_SHIFT;
		in_ellipse = !sat_s2 && (hi <= eaf_pkg::SUM_W'(eaf_pkg::DIST_ONE));
		mid.in_ellipse = in_ellipse;
		mid.distance   = in_ellipse ? hi[eaf_pkg::DIST_W-1:0] :
			eaf_pkg::DIST_W'(eaf_pkg::DIST_ONE);
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			p_x_s1  <= prod_x;
			p_y_s1  <= prod_y;
			sq_x_s2 <= eaf_pkg::SQ_W'(pt_x) * eaf_pkg::SQ_W'(pt_x);
			sq_y_s2 <= eaf_pkg::SQ_W'(pt_y) * eaf_pkg::SQ_W'(pt_y);
			sat_s2  <= sat;
			mid_s3  <= mid;
		end
	end

endmodule

>>> hdl/eaf_back.sv
// Back part: finds the alpha for a distance by a pipelined bitwise search of the log table.
module eaf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  eaf_pkg::word_t in_word,
	output logic           in_pop,
	output logic           out_push,
	output eaf_pkg::word_t out_word,
	input  logic           out_full
);

	logic                           adv;
	eaf_pkg::mid_word_t             mid;
	eaf_pkg::res_word_t             res;
	logic [eaf_pkg::DIST_W-1:0]     remain;

	// Stage 0 holds the right-hand side; each later stage settles one alpha bit.
	logic                           v_s      [eaf_pkg::SRCH_STEPS+1];
	logic                           in_ell_s [eaf_pkg::SRCH_STEPS+1];
	logic [eaf_pkg::ALPHA_W-1:0]    alpha_s  [eaf_pkg::SRCH_STEPS+1];
	logic [eaf_pkg::RHS_W-1:0]      rhs_s    [eaf_pkg::SRCH_STEPS];
	logic [eaf_pkg::ALPHA_W-1:0]    cand     [eaf_pkg::SRCH_STEPS];
	logic [eaf_pkg::RHS_W-1:0]      lhs      [eaf_pkg::SRCH_STEPS];
	logic                           keep     [eaf_pkg::SRCH_STEPS];

	assign adv      = !(v_s[eaf_pkg::SRCH_STEPS] && out_full);
	assign in_pop   = in_valid && adv;
	assign out_push = v_s[eaf_pkg::SRCH_STEPS] && !out_full;
	assign mid      = eaf_pkg::mid_word_t'(in_word[eaf_pkg::MID_W-1:0]);
	assign remain   = eaf_pkg::DIST_W'(eaf_pkg::DIST_ONE) - mid.distance;

	// Outside pixels get alpha zero.
	always_comb begin
		res.in_ellipse = in_ell_s[eaf_pkg::SRCH_STEPS];
		res.alpha      = in_ell_s[eaf_pkg::SRCH_STEPS] ? alpha_s[eaf_pkg::SRCH_STEPS] : '0;
	end
	assign out_word = eaf_pkg::WORD_W'(res);

	// Keep a bit when N * log2(candidate) stays within the right-hand side.
	always_comb begin
		for (int k = 0; k < eaf_pkg::SRCH_STEPS; k++) begin
			cand[k] = alpha_s[k] |
				(eaf_pkg::ALPHA_W'(1) << (eaf_pkg::SRCH_STEPS - 1 - k));
			lhs[k]  = eaf_pkg::RHS_W'(eaf_pkg::LOG2_TBL[cand[k]]) <<
				eaf_pkg::DIST_FRAC_BITS;
			keep[k] = (lhs[k] <= rhs_s[k]);
		end
	end

	// Valid bits of all search stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= eaf_pkg::SRCH_STEPS; k++)
				v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_pop;
			for (int k = 0; k < eaf_pkg::SRCH_STEPS; k++)
				v_s[k+1] <= v_s[k];
		end
	end

	// Stage 0 forms (N - d) * log2(255); later stages carry it and refine alpha.
	always_ff @(posedge clk) begin
		if (adv) begin
			rhs_s[0]    <= eaf_pkg::RHS_W'(remain) *
				eaf_pkg::RHS_W'(eaf_pkg::LOG2_TBL[255]);
			in_ell_s[0] <= mid.in_ellipse;
			alpha_s[0]  <= '0;
			for (int k = 0; k < eaf_pkg::SRCH_STEPS; k++) begin
				in_ell_s[k+1] <= in_ell_s[k];
				alpha_s[k+1]  <= keep[k] ? cand[k] : alpha_s[k];
			end
			for (int k = 0; k < eaf_pkg::SRCH_STEPS - 1; k++)
				rhs_s[k+1] <= rhs_s[k];
		end
	end

endmodule

>>> hdl/elliptical_alpha_falloff.sv
// Elliptical alpha falloff mask: one alpha per pixel coordinate.
// Path: a pixel passes 3 front stages, the middle queue, 9 back stages and the result
// queue before its result can be popped. Throughput: one pixel per cycle unless a full
// result queue holds the pipeline, set by the fully pipelined multipliers and search stages.
// Reset: arst_n clears all queues and valid bits and loads the registers with
// 256, 256, 512, 512; pixels may be pushed on the first cycle after reset.
module elliptical_alpha_falloff (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [eaf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [eaf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [eaf_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [eaf_pkg::COORD_BITS-1:0]  pixel_y,
	output logic                            empty,
	input  logic                            pop,
	output logic [eaf_pkg::ALPHA_W-1:0]     alpha,
	output logic                            inside_res
);

	eaf_pkg::cfg_t       cfg_q;
	logic                mid_push;
	eaf_pkg::word_t      mid_wdata;
	logic                mid_full;
	logic                mid_pop;
	eaf_pkg::word_t      mid_rdata;
	logic                mid_empty;
	logic                res_push;
	eaf_pkg::word_t      res_wdata;
	logic                res_full;
	eaf_pkg::word_t      res_rdata;
	eaf_pkg::res_word_t  res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= eaf_pkg::RST_IMAGE_SIZE;
			cfg_q.image_height <= eaf_pkg::RST_IMAGE_SIZE;
			cfg_q.recip_coef_x <= eaf_pkg::RST_RECIP_COEF;
			cfg_q.recip_coef_y <= eaf_pkg::RST_RECIP_COEF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				eaf_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[eaf_pkg::SIZE_W-1:0];
				eaf_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[eaf_pkg::SIZE_W-1:0];
				eaf_pkg::REG_RECIP_COEF_X: cfg_q.recip_coef_x <= cfg_data[eaf_pkg::COEF_W-1:0];
				eaf_pkg::REG_RECIP_COEF_Y: cfg_q.recip_coef_y <= cfg_data[eaf_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front part.
	eaf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.full     (full),
		.out_push (mid_push),
		.out_word (mid_wdata),
		.out_full (mid_full)
	);

	// Queue between the front and back parts.
	eaf_fifo u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	// Back part.
	eaf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_word  (mid_rdata),
		.in_pop   (mid_pop),
		.out_push (res_push),
		.out_word (res_wdata),
		.out_full (res_full)
	);

	// Result queue facing the consumer.
	eaf_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res        = eaf_pkg::res_word_t'(res_rdata[eaf_pkg::RES_W-1:0]);
	assign alpha      = res.alpha;
	assign inside_res = res.in_ellipse;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the elliptical alpha falloff block.
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX    = 10;

	// One expected alpha word together with the pixel that produced it.
	typedef struct {
		logic [eaf_pkg::COORD_BITS-1:0] px;
		logic [eaf_pkg::COORD_BITS-1:0] py;
		logic [eaf_pkg::ALPHA_W-1:0]    alpha;
		logic                           in_ellipse;
	} alpha_exp_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [eaf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [eaf_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           push;
	logic                           full;
	logic [eaf_pkg::COORD_BITS-1:0] pixel_x;
	logic [eaf_pkg::COORD_BITS-1:0] pixel_y;
	logic                           empty;
	logic                           pop;
	logic [eaf_pkg::ALPHA_W-1:0]    alpha;
	logic                           inside_res;

	// Local copy of the mask geometry registers.
	logic [eaf_pkg::SIZE_W-1:0] geo_width;
	logic [eaf_pkg::SIZE_W-1:0] geo_height;
	logic [eaf_pkg::COEF_W-1:0] geo_coef_x;
	logic [eaf_pkg::COEF_W-1:0] geo_coef_y;

	logic [63:0] log2_tab [256];
	alpha_exp_t  alpha_q [$];

	bit idle_on;
	bit rx_hold_req;
	int cycle_cnt;
	int pixels_sent;
	int alphas_checked;
	int settings_used;
	int mismatch_cnt;
	int fail_cnt;

	elliptical_alpha_falloff u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.empty      (empty),
		.pop        (pop),
		.alpha      (alpha),
		.inside_res (inside_res)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d alphas still expected",
				cycle_cnt, alpha_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// log2 of v as unsigned Q3.32, by repeated squaring of a truncated Q1.31 mantissa.
	function automatic logic [63:0] log2_fix(input int unsigned v);
		int unsigned ex;
		logic [63:0] mant;
		logic [63:0] acc;
		ex = 0;
		while (ex < 7 && (v >> (ex + 1)) != 0)
			ex++;
		mant = 64'(v) << (31 - ex);
		acc  = 64'(ex) << 32;
		for (int b = 31; b >= 0; b--) begin
			mant = (mant * mant) >> 31;
			if (mant >= 64'h1_0000_0000) begin
				mant = mant >> 1;
				acc[b] = 1'b1;
			end
		end
		return acc;
	endfunction

	// Squared offset from the center, scaled by the reciprocal radius, saturating.
	function automatic logic [63:0] scaled_sq(input logic [eaf_pkg::COORD_BITS-1:0] c,
			input logic [eaf_pkg::SIZE_W-1:0] size, input logic [eaf_pkg::COEF_W-1:0] coef);
		logic [63:0] twice;
		logic [63:0] mag;
		logic [63:0] prod;
		twice = 64'(c) << 1;
		mag   = (twice >= 64'(size)) ? twice - 64'(size) : 64'(size) - twice;
		prod  = mag * 64'(coef);
		if (prod >= 64'h1_0000_0000)
			return '1;
		return prod * prod;
	endfunction

	// Alpha of one pixel under the current geometry.
	function automatic alpha_exp_t predict_alpha(input logic [eaf_pkg::COORD_BITS-1:0] px,
			input logic [eaf_pkg::COORD_BITS-1:0] py);
		logic [63:0] tx;
		logic [63:0] ty;
		logic [63:0] sum;
		logic [63:0] distance;
		logic [63:0] one;
		logic [63:0] rhs;
		int lo;
		int hi;
		int mid;
		alpha_exp_t e;
		one = 64'd1 << eaf_pkg::DIST_FRAC_BITS;
		tx  = scaled_sq(px, geo_width, geo_coef_x);
		ty  = scaled_sq(py, geo_height, geo_coef_y);
		sum = (tx > ~ty) ? '1 : tx + ty;
		distance = sum >> (34 - eaf_pkg::DIST_FRAC_BITS);
		e.px = px;
		e.py = py;
		if (distance > one) begin
			e.alpha      = '0;
			e.in_ellipse = 1'b0;
		end else begin
			// Largest alpha whose log fits under the remaining distance.
			rhs = (one - distance) * log2_tab[255];
			lo = 1;
			hi = 255;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (one * log2_tab[mid] <= rhs)
					lo = mid;
				else
					hi = mid - 1;
			end
			e.alpha      = eaf_pkg::ALPHA_W'(lo);
			e.in_ellipse = 1'b1;
		end
		return e;
	endfunction

	// Predict on every accepted pixel, check every accepted alpha word.
	always @(posedge clk) begin
		alpha_exp_t e;
		if (arst_n) begin
			if (push && !full) begin
				alpha_q.push_back(predict_alpha(pixel_x, pixel_y));
				pixels_sent++;
			end
			if (pop && !empty) begin
				alphas_checked++;
				if (alpha_q.size() == 0) begin
					fail_cnt++;
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("Unexpected word: alpha %0d inside %0d", alpha, inside_res);
				end else begin
					e = alpha_q.pop_front();
					if (alpha !== e.alpha || inside_res !== e.in_ellipse) begin
						fail_cnt++;
						mismatch_cnt++;
						// Values are given as alpha/inside.
						if (mismatch_cnt <= REPORT_MAX)
							$display("Mismatch at (%0d,%0d): exp %0d/%0d got %0d/%0d",
								e.px, e.py, e.alpha, e.in_ellipse, alpha, inside_res);
					end
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold on request.
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
				pop <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offer one pixel until it is taken, then maybe leave a gap.
	task automatic send_pixel(input logic [eaf_pkg::COORD_BITS-1:0] x,
			input logic [eaf_pkg::COORD_BITS-1:0] y);
		push    <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected alpha has come out.
	task automatic drain_alphas();
		push <= 1'b0;
		while (alpha_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load all four geometry registers; only called while the block is idle.
	task automatic set_geometry(input logic [eaf_pkg::CFG_DATA_W-1:0] w,
			input logic [eaf_pkg::CFG_DATA_W-1:0] h,
			input logic [eaf_pkg::CFG_DATA_W-1:0] cx,
			input logic [eaf_pkg::CFG_DATA_W-1:0] cy);
		logic [eaf_pkg::CFG_DATA_W-1:0] vals [4];
		logic [eaf_pkg::CFG_IDX_W-1:0]  idxs [4];
		drain_alphas();
		vals = '{w, h, cx, cy};
		idxs = '{eaf_pkg::REG_IMAGE_WIDTH, eaf_pkg::REG_IMAGE_HEIGHT,
			eaf_pkg::REG_RECIP_COEF_X, eaf_pkg::REG_RECIP_COEF_Y};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		geo_width  = w[eaf_pkg::SIZE_W-1:0];
		geo_height = h[eaf_pkg::SIZE_W-1:0];
		geo_coef_x = cx[eaf_pkg::COEF_W-1:0];
		geo_coef_y = cy[eaf_pkg::COEF_W-1:0];
		settings_used++;
	endtask

	// Coordinate near the ellipse along one axis, sometimes anywhere.
	function automatic logic [eaf_pkg::COORD_BITS-1:0] pick_coord(
			input logic [eaf_pkg::SIZE_W-1:0] size, input logic [eaf_pkg::COEF_W-1:0] coef);
		int span;
		int center;
		int off;
		int c;
		if (coef == 0 || $urandom_range(0, 7) == 0)
			return eaf_pkg::COORD_BITS'($urandom);
		span   = 65536 / int'(coef);
		span   = span + span / 4 + 2;
		center = int'(size) / 2;
		off    = int'($urandom_range(0, span));
		c      = ($urandom_range(0, 1) == 1) ? center + off : center - off;
		if (c < 0)
			c = 0;
		if (c > (1 << eaf_pkg::COORD_BITS) - 1)
			c = (1 << eaf_pkg::COORD_BITS) - 1;
		return eaf_pkg::COORD_BITS'(c);
	endfunction

	task automatic send_random_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(pick_coord(geo_width, geo_coef_x), pick_coord(geo_height, geo_coef_y));
	endtask

	// Reset geometry: center, ellipse rim, just inside, far corners.
	task automatic test_reset_geometry();
		send_pixel(12'd128, 12'd128);
		send_pixel(12'd129, 12'd128);
		send_pixel(12'd0, 12'd128);
		send_pixel(12'd256, 12'd128);
		send_pixel(12'd128, 12'd0);
		send_pixel(12'd128, 12'd256);
		send_pixel(12'd255, 12'd128);
		send_pixel(12'd192, 12'd128);
		send_pixel(12'd160, 12'd160);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		drain_alphas();
	endtask

	// Register extremes: oversized and zero sizes, zero and widest coefficients.
	task automatic test_register_extremes();
		// Width wraps to 8191, zero height, x ignored, steep y.
		set_geometry(17'h1FFFF, 17'd0, 17'd0, 17'd65536);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd1);
		// One-pixel image with coefficient 65536 on both axes.
		set_geometry(17'd1, 17'd1, 17'd65536, 17'd65536);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd2, 12'd0);
		// Widest coefficient on x, gentlest on y.
		set_geometry(17'd4096, 17'd4096, 17'h1FFFF, 17'd1);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd2049, 12'd0);
		send_pixel(12'd0, 12'd4095);
		drain_alphas();
	endtask

	// A series of geometries, each with near-ellipse random pixels.
	task automatic test_random_geometries();
		for (int s = 0; s < 8; s++) begin
			case (s)
				0: set_geometry(17'd256, 17'd256, 17'd512, 17'd512);
				1: set_geometry(17'd4096, 17'd4096, 17'd32, 17'd64);
				2: set_geometry(17'd640, 17'd480, 17'd200, 17'd300);
				default: set_geometry(eaf_pkg::CFG_DATA_W'($urandom_range(1, 4096)),
					eaf_pkg::CFG_DATA_W'($urandom_range(1, 4096)),
					eaf_pkg::CFG_DATA_W'($urandom_range(1, 4096)),
					eaf_pkg::CFG_DATA_W'($urandom_range(1, 4096)));
			endcase
			// One setting runs back to back with no idling at all.
			idle_on = (s != 3);
			send_random_pixels(185);
		end
		idle_on = 1'b1;
		drain_alphas();
	endtask

	// Long result hold while pixels keep coming, then a full drain mid-stream.
	task automatic test_backpressure();
		set_geometry(17'd1024, 17'd768, 17'd128, 17'd170);
		idle_on = 1'b0;
		rx_hold_req = 1'b1;
		send_random_pixels(80);
		drain_alphas();
		idle_on = 1'b1;
		send_random_pixels(40);
		drain_alphas();
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		set_geometry(17'd320, 17'd200, 17'd400, 17'd655);
		idle_on = 1'b0;
		send_random_pixels(250);
		drain_alphas();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		push        = 1'b0;
		pixel_x     = '0;
		pixel_y     = '0;
		idle_on     = 1'b1;
		rx_hold_req = 1'b0;
		cycle_cnt   = 0;
		geo_width   = eaf_pkg::RST_IMAGE_SIZE;
		geo_height  = eaf_pkg::RST_IMAGE_SIZE;
		geo_coef_x  = eaf_pkg::RST_RECIP_COEF;
		geo_coef_y  = eaf_pkg::RST_RECIP_COEF;
		for (int i = 0; i < 256; i++)
			log2_tab[i] = (i == 0) ? 64'd0 : log2_fix(i);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_register_extremes();
		test_random_geometries();
		test_backpressure();
		test_full_rate();

		if (alpha_q.size() != 0)
			fail_cnt++;
		$display("Covered %0d pixels over %0d register settings, long holds and idle gaps.",
			pixels_sent, settings_used + 1);
		$display("Alpha words checked: %0d, mismatches: %0d.", alphas_checked, mismatch_cnt);
		if (fail_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
